@@ sv/assert_macros.svh @@
// assertion macros used by the port checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define ASSERT_IMPLY(lbl, clk, rstn, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (b)) \
    else $error("implication check failed");

// next-cycle implication, disabled while reset is low
`define ASSERT_NEXT(lbl, clk, rstn, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (b)) \
    else $error("next-cycle check failed");

`endif

@@ sv/cht_pkg.sv @@
// shared types, codes and the letter map of the hash table core
package cht_pkg;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_FIND   = 2'd2,
    OP_NOP    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_DUP     = 2'd1,
    ST_MISSING = 2'd2,
    ST_FULL    = 2'd3
  } status_e;

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_DUP,
    S_WALK_RD,
    S_WALK,
    S_PROBE,
    S_LINK,
    S_R1,
    S_R1A_RD,
    S_R1A,
    S_CLRNX,
    S_RP,
    S_RN_RD,
    S_RN,
    S_CLRS,
    S_DONE
  } state_e;

  localparam int unsigned RADIX  = 33;
  localparam int unsigned HASH_W = 16;

  // cp1251 letter to alphabet position, 0 for anything else
  function automatic logic [5:0] letter_pos(logic [7:0] b);
    logic [7:0] off;
    off = 8'd0;
    if (b == 8'hB8 || b == 8'hA8) begin
      return 6'd7;
    end
    if (b >= 8'hE0) begin
      off = b - 8'hE0;
    end else if (b >= 8'hC0) begin
      off = b - 8'hC0;
    end else begin
      return 6'd0;
    end
    return (off < 8'd6) ? 6'(off + 8'd1) : 6'(off + 8'd2);
  endfunction

endpackage

@@ sv/cht_req_if.sv @@
// request and response channel interfaces
interface cht_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [63:0] key_text;
  logic [63:0] value;

  modport source (output valid, output operation, output key_text, output value,
                  input ready);
  modport sink   (input valid, input operation, input key_text, input value,
                  output ready);
endinterface

interface cht_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [63:0] found_value;

  modport source (output valid, output status, output found_value, input ready);
  modport sink   (input valid, input status, input found_value, output ready);
endinterface

@@ sv/coalesced_hash_table_core.sv @@
// coalesced hash table with doubly linked chains kept in one slot memory
//
//  channel | dir | payload                          | accepted when
//  req_i   | in  | operation, key_text, value       | valid && ready
//  rsp_o   | out | status, found_value              | valid && ready
//
//  after reset a clearing pass writes every slot, req not ready meanwhile
//  an item is hashed first, then takes one memory access per step:
//  add scans all slots for a duplicate, walks the chain and probes for a free slot
//  find and remove walk the chain, remove then rewrites the neighbour slots and clears one
//  the slot memory sets the pace; a finished result waits in the output
//  register while the next item is taken, and a stalled rsp holds the core in S_DONE
module coalesced_hash_table_core #(
  parameter int unsigned TABLE_SIZE = 32,
  parameter int unsigned KEY_BYTES  = 8
) (
  input  logic clk_i,
  input  logic rst_ni,
  cht_req_if.sink   req_i,
  cht_rsp_if.source rsp_o
);

  localparam int unsigned IW = $clog2(TABLE_SIZE);
  localparam int unsigned LW = IW + 1;
  localparam int unsigned CW = IW + 1;
  localparam logic [LW-1:0] LINK_NONE = {LW{1'b1}};
  localparam logic [63:0]   KEY_MASK  = {64{1'b1}} >> (64 - 8*KEY_BYTES);

  typedef struct packed {
    logic          used;
    logic [63:0]   key;
    logic [63:0]   val;
    logic [LW-1:0] nxt;
    logic [LW-1:0] prv;
  } ent_t;

  localparam ent_t ENT_CLEAR = '{used: 1'b0, key: '0, val: '0,
                                 nxt: LINK_NONE, prv: LINK_NONE};

  cht_pkg::state_e state_q, state_d;
  cht_pkg::op_e    op_q, op_d;
  logic [63:0]     key_q, key_d, val_q, val_d;
  logic [IW-1:0]   cur_q, cur_d, prb_q, prb_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  ent_t            ent_q, ent_d;
  logic [LW-1:0]   aft_q, aft_d;
  cht_pkg::status_e res_status_q, res_status_d;
  logic [63:0]     res_found_q, res_found_d;
  logic            out_valid_q, out_valid_d;
  logic [1:0]      out_status_q, out_status_d;
  logic [63:0]     out_found_q, out_found_d;

  ent_t            mem_q [TABLE_SIZE];
  ent_t            rdata_q, wdata;
  logic            we;
  logic [IW-1:0]   waddr, raddr;

  logic            req_acc, hash_start, hash_done;
  logic [IW-1:0]   home;
  logic [63:0]     req_key;
  logic            key_hit, nxt_ok, prv_ok, ent_nxt_ok;
  logic [IW-1:0]   nxt_idx, cur_inc, prb_inc;

  assign req_key    = req_i.key_text & KEY_MASK;
  assign req_acc    = req_i.valid && req_i.ready;
  assign req_i.ready = (state_q == cht_pkg::S_IDLE);
  assign hash_start = req_acc && (cht_pkg::op_e'(req_i.operation) != cht_pkg::OP_NOP);

  cht_hash #(
    .TABLE_SIZE (TABLE_SIZE),
    .KEY_BYTES  (KEY_BYTES)
  ) u_hash (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (hash_start),
    .key_i   (req_key),
    .done_o  (hash_done),
    .home_o  (home)
  );

  assign key_hit    = rdata_q.used && (rdata_q.key == key_q);
  assign nxt_ok     = rdata_q.nxt < LW'(TABLE_SIZE);
  assign prv_ok     = rdata_q.prv < LW'(TABLE_SIZE);
  assign ent_nxt_ok = ent_q.nxt < LW'(TABLE_SIZE);
  assign nxt_idx    = rdata_q.nxt[IW-1:0];
  assign cur_inc    = (cur_q == IW'(TABLE_SIZE-1)) ? '0 : cur_q + 1'b1;
  assign prb_inc    = (prb_q == IW'(TABLE_SIZE-1)) ? '0 : prb_q + 1'b1;

  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    key_d        = key_q;
    val_d        = val_q;
    cur_d        = cur_q;
    prb_d        = prb_q;
    cnt_d        = cnt_q;
    ent_d        = ent_q;
    aft_d        = aft_q;
    res_status_d = res_status_q;
    res_found_d  = res_found_q;
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_found_d  = out_found_q;
    we           = 1'b0;
    waddr        = cur_q;
    wdata        = ENT_CLEAR;
    raddr        = cur_q;

    if (rsp_o.valid && rsp_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      cht_pkg::S_CLEAR: begin
        we    = 1'b1;
        waddr = cnt_q[IW-1:0];
        if (cnt_q == CW'(TABLE_SIZE-1)) begin
          cnt_d   = '0;
          state_d = cht_pkg::S_IDLE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      cht_pkg::S_IDLE: begin
        if (req_acc) begin
          op_d         = cht_pkg::op_e'(req_i.operation);
          key_d        = req_key;
          val_d        = req_i.value;
          res_status_d = cht_pkg::ST_OK;
          res_found_d  = '0;
          state_d      = (cht_pkg::op_e'(req_i.operation) == cht_pkg::OP_NOP)
                       ? cht_pkg::S_DONE : cht_pkg::S_HASH;
        end
      end
      cht_pkg::S_HASH: begin
        if (hash_done) begin
          cur_d   = home;
          cnt_d   = '0;
          state_d = (op_q == cht_pkg::OP_ADD) ? cht_pkg::S_DUP : cht_pkg::S_WALK_RD;
        end
      end
      cht_pkg::S_DUP: begin
        // read slot cnt while checking the data of slot cnt-1
        raddr = cnt_q[IW-1:0];
        if (cnt_q != '0 && key_hit) begin
          res_status_d = cht_pkg::ST_DUP;
          state_d      = cht_pkg::S_DONE;
        end else if (cnt_q == CW'(TABLE_SIZE)) begin
          cnt_d   = '0;
          state_d = cht_pkg::S_WALK_RD;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      cht_pkg::S_WALK_RD: begin
        raddr   = cur_q;
        state_d = cht_pkg::S_WALK;
      end
      cht_pkg::S_WALK: begin
        if (op_q == cht_pkg::OP_ADD) begin
          if (cnt_q < CW'(TABLE_SIZE) && nxt_ok) begin
            cur_d = nxt_idx;
            raddr = nxt_idx;
            cnt_d = cnt_q + 1'b1;
          end else begin
            ent_d = rdata_q;
            if (!rdata_q.used) begin
              we      = 1'b1;
              waddr   = cur_q;
              wdata   = '{used: 1'b1, key: key_q, val: val_q,
                          nxt: LINK_NONE, prv: LINK_NONE};
              state_d = cht_pkg::S_DONE;
            end else begin
              raddr   = cur_inc;
              prb_d   = cur_inc;
              cnt_d   = CW'(1);
              state_d = cht_pkg::S_PROBE;
            end
          end
        end else if (key_hit) begin
          ent_d = rdata_q;
          if (op_q == cht_pkg::OP_FIND) begin
            res_found_d = rdata_q.val;
            state_d     = cht_pkg::S_DONE;
          end else if (nxt_ok && !prv_ok) begin
            // chain head with a successor: pull the successor forward
            raddr   = nxt_idx;
            state_d = cht_pkg::S_R1;
          end else if (prv_ok) begin
            raddr   = rdata_q.prv[IW-1:0];
            state_d = cht_pkg::S_RP;
          end else begin
            state_d = cht_pkg::S_CLRS;
          end
        end else if (!nxt_ok || cnt_q == CW'(TABLE_SIZE-1)) begin
          res_status_d = cht_pkg::ST_MISSING;
          state_d      = cht_pkg::S_DONE;
        end else begin
          cur_d = nxt_idx;
          raddr = nxt_idx;
          cnt_d = cnt_q + 1'b1;
        end
      end
      cht_pkg::S_PROBE: begin
        if (!rdata_q.used) begin
          we      = 1'b1;
          waddr   = prb_q;
          wdata   = '{used: 1'b1, key: key_q, val: val_q,
                      nxt: LINK_NONE, prv: LW'(cur_q)};
          state_d = cht_pkg::S_LINK;
        end else if (cnt_q == CW'(TABLE_SIZE)) begin
          res_status_d = cht_pkg::ST_FULL;
          state_d      = cht_pkg::S_DONE;
        end else begin
          raddr = prb_inc;
          prb_d = prb_inc;
          cnt_d = cnt_q + 1'b1;
        end
      end
      cht_pkg::S_LINK: begin
        we        = 1'b1;
        waddr     = cur_q;
        wdata     = ent_q;
        wdata.nxt = LW'(prb_q);
        state_d   = cht_pkg::S_DONE;
      end
      cht_pkg::S_R1: begin
        we      = 1'b1;
        waddr   = cur_q;
        wdata   = '{used: rdata_q.used, key: rdata_q.key, val: rdata_q.val,
                    nxt: rdata_q.nxt, prv: LINK_NONE};
        aft_d   = rdata_q.nxt;
        state_d = nxt_ok ? cht_pkg::S_R1A_RD : cht_pkg::S_CLRNX;
      end
      cht_pkg::S_R1A_RD: begin
        raddr   = aft_q[IW-1:0];
        state_d = cht_pkg::S_R1A;
      end
      cht_pkg::S_R1A: begin
        we        = 1'b1;
        waddr     = aft_q[IW-1:0];
        wdata     = rdata_q;
        wdata.prv = LW'(cur_q);
        state_d   = cht_pkg::S_CLRNX;
      end
      cht_pkg::S_CLRNX: begin
        we      = 1'b1;
        waddr   = ent_q.nxt[IW-1:0];
        state_d = cht_pkg::S_DONE;
      end
      cht_pkg::S_RP: begin
        // predecessor skips the removed slot
        we        = 1'b1;
        waddr     = ent_q.prv[IW-1:0];
        wdata     = rdata_q;
        wdata.nxt = ent_q.nxt;
        state_d   = ent_nxt_ok ? cht_pkg::S_RN_RD : cht_pkg::S_CLRS;
      end
      cht_pkg::S_RN_RD: begin
        raddr   = ent_q.nxt[IW-1:0];
        state_d = cht_pkg::S_RN;
      end
      cht_pkg::S_RN: begin
        we        = 1'b1;
        waddr     = ent_q.nxt[IW-1:0];
        wdata     = rdata_q;
        wdata.prv = ent_q.prv;
        state_d   = cht_pkg::S_CLRS;
      end
      cht_pkg::S_CLRS: begin
        we      = 1'b1;
        waddr   = cur_q;
        state_d = cht_pkg::S_DONE;
      end
      cht_pkg::S_DONE: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_found_d  = res_found_q;
          state_d      = cht_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = cht_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cht_pkg::S_CLEAR;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    key_q        <= key_d;
    val_q        <= val_d;
    cur_q        <= cur_d;
    prb_q        <= prb_d;
    ent_q        <= ent_d;
    aft_q        <= aft_d;
    res_status_q <= res_status_d;
    res_found_q  <= res_found_d;
    out_status_q <= out_status_d;
    out_found_q  <= out_found_d;
  end

  // slot memory, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    rdata_q <= mem_q[raddr];
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.status      = out_status_q;
  assign rsp_o.found_value = out_found_q;

endmodule

@@ sv/cht_hash.sv @@
// home slot unit: letter map, base-33 value, remainder by table size through a reciprocal
module cht_hash #(
  parameter int unsigned TABLE_SIZE = 32,
  parameter int unsigned KEY_BYTES  = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [63:0]                   key_i,
  output logic                          done_o,
  output logic [$clog2(TABLE_SIZE)-1:0] home_o
);

  localparam int unsigned IW = $clog2(TABLE_SIZE);
  localparam int unsigned HW = cht_pkg::HASH_W;
  // scaled reciprocal, gives the exact quotient for every base-33 value
  localparam logic [32:0] RECIP = 33'((64'd1 << 32) / 64'(TABLE_SIZE) + 64'd1);

  logic [5:0]    c0, c1, c2;
  logic [HW-1:0] hval;
  logic [HW+32:0] prod;
  logic [HW-1:0] rem_full;
  logic [HW-1:0] hval_q, hval2_q, quo_q;
  logic [IW-1:0] rem_q;
  logic          v1_q, v2_q, done_q;

  assign c0 = cht_pkg::letter_pos(key_i[8*(KEY_BYTES-1) +: 8]);
  assign c1 = cht_pkg::letter_pos(key_i[8*(KEY_BYTES-2) +: 8]);
  assign c2 = cht_pkg::letter_pos(key_i[8*(KEY_BYTES-3) +: 8]);
  assign hval = HW'(c0) * HW'(cht_pkg::RADIX * cht_pkg::RADIX)
              + HW'(c1) * HW'(cht_pkg::RADIX) + HW'(c2);

  // quotient in the second stage, remainder in the third
  assign prod     = (HW+33)'(hval_q) * (HW+33)'(RECIP);
  assign rem_full = hval2_q - HW'(quo_q * HW'(TABLE_SIZE));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      v1_q   <= start_i;
      v2_q   <= v1_q;
      done_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      hval_q <= hval;
    end
    hval2_q <= hval_q;
    quo_q   <= prod[32 +: HW];
    rem_q   <= rem_full[IW-1:0];
  end

  assign done_o = done_q;
  assign home_o = rem_q;

endmodule

@@ sv/cht_checker.sv @@
// port-level checks for the hash table core, bound into every instance of the core
`include "assert_macros.svh"

module cht_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        req_valid,
  input logic        req_ready,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [1:0]  rsp_status,
  input logic [63:0] rsp_found
);

  logic [1:0] pend_q, pend_d;
  logic       req_acc, rsp_acc;

  assign req_acc = req_valid && req_ready;
  assign rsp_acc = rsp_valid && rsp_ready;

  // items taken but not yet answered
  always_comb begin
    pend_d = pend_q;
    if (req_acc && !rsp_acc) begin
      pend_d = pend_q + 2'd1;
    end else if (!req_acc && rsp_acc) begin
      pend_d = pend_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  `ASSERT_IMPLY(a_no_invented, clk_i, rst_ni, rsp_valid, pend_q != 2'd0)
  `ASSERT_IMPLY(a_one_in_flight, clk_i, rst_ni, req_acc, pend_q != 2'd2)
  `ASSERT_IMPLY(a_found_zero, clk_i, rst_ni, rsp_valid && rsp_status != cht_pkg::ST_OK, rsp_found == 64'd0)
  `ASSERT_NEXT(a_rsp_hold, clk_i, rst_ni, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_found))

endmodule

bind coalesced_hash_table_core cht_checker u_cht_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .req_valid  (req_i.valid),
  .req_ready  (req_i.ready),
  .rsp_valid  (rsp_o.valid),
  .rsp_ready  (rsp_o.ready),
  .rsp_status (rsp_o.status),
  .rsp_found  (rsp_o.found_value)
);

@@ dv/cht_tb_if.sv @@
// the testbench drives the channel interfaces declared with the rtl, nothing else lives here

@@ dv/tb_coalesced_hash_table_core.sv @@
// testbench of the coalesced hash table core: random and directed requests checked against a predictor
module tb_coalesced_hash_table_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SLOTS = 32;
  localparam int unsigned NO_LINK = 63;

  typedef struct packed {
    cht_pkg::status_e status;
    logic [63:0]      found_value;
  } answer_t;

  class answer_board;
    logic [63:0] keys [SLOTS];
    logic [63:0] vals [SLOTS];
    bit          used [SLOTS];
    int unsigned nxt  [SLOTS];
    int unsigned prv  [SLOTS];
    answer_t     pending [$];
    int          errors;

    function void wipe(int unsigned s);
      keys[s] = '0; vals[s] = '0; used[s] = 0; nxt[s] = NO_LINK; prv[s] = NO_LINK;
    endfunction

    function new();
      errors = 0;
      for (int unsigned s = 0; s < SLOTS; s++) wipe(s);
    endfunction

    function int unsigned home_of(logic [63:0] k);
      int unsigned v;
      v = 0;
      for (int i = 0; i < 3; i++)
        v = v * cht_pkg::RADIX + 32'(cht_pkg::letter_pos(k[63-8*i -: 8]));
      return v % SLOTS;
    endfunction

    function int unsigned locate(logic [63:0] k);
      int unsigned s;
      s = home_of(k);
      for (int n = 0; n < SLOTS; n++) begin
        if (used[s] && keys[s] == k) return s;
        if (nxt[s] >= SLOTS) return NO_LINK;
        s = nxt[s];
      end
      return NO_LINK;
    endfunction

    function cht_pkg::status_e insert(logic [63:0] k, logic [63:0] v);
      int unsigned s, p;
      for (int unsigned i = 0; i < SLOTS; i++)
        if (used[i] && keys[i] == k) return cht_pkg::ST_DUP;
      s = home_of(k);
      for (int n = 0; n < SLOTS && nxt[s] < SLOTS; n++) s = nxt[s];
      if (!used[s]) begin
        keys[s] = k; vals[s] = v; used[s] = 1; nxt[s] = NO_LINK; prv[s] = NO_LINK;
        return cht_pkg::ST_OK;
      end
      p = s;
      for (int n = 0; n < SLOTS; n++) begin
        p = (p + 1) % SLOTS;
        if (!used[p]) begin
          keys[p] = k; vals[p] = v; used[p] = 1; nxt[p] = NO_LINK; prv[p] = s; nxt[s] = p;
          return cht_pkg::ST_OK;
        end
      end
      return cht_pkg::ST_FULL;
    endfunction

    function cht_pkg::status_e unlink(logic [63:0] k);
      int unsigned s, nx, pv, aft;
      s = locate(k);
      if (s == NO_LINK) return cht_pkg::ST_MISSING;
      nx = nxt[s]; pv = prv[s];
      if (nx < SLOTS && pv >= SLOTS) begin
        // head with successor: pull the successor into the head slot
        aft = nxt[nx];
        keys[s] = keys[nx]; vals[s] = vals[nx]; used[s] = used[nx];
        nxt[s] = aft; prv[s] = NO_LINK;
        if (aft < SLOTS) prv[aft] = s;
        wipe(nx);
      end else if (nx < SLOTS) begin
        nxt[pv] = nx; prv[nx] = pv; wipe(s);
      end else begin
        if (pv < SLOTS) nxt[pv] = NO_LINK;
        wipe(s);
      end
      return cht_pkg::ST_OK;
    endfunction

    function void note_request(logic [1:0] op, logic [63:0] k, logic [63:0] v);
      answer_t a;
      int unsigned s;
      a.status = cht_pkg::ST_OK; a.found_value = '0;
      case (op)
        cht_pkg::OP_ADD:    a.status = insert(k, v);
        cht_pkg::OP_REMOVE: a.status = unlink(k);
        cht_pkg::OP_FIND: begin
          s = locate(k);
          if (s == NO_LINK) a.status = cht_pkg::ST_MISSING;
          else a.found_value = vals[s];
        end
        default: ;
      endcase
      pending.push_back(a);
    endfunction

    function void check_answer(logic [1:0] st, logic [63:0] fv);
      answer_t a;
      if (pending.size() == 0) begin
        $display("%0t unexpected response status %0d value %h", $time, st, fv);
        errors++;
        return;
      end
      a = pending.pop_front();
      if (st !== a.status) begin
        $display("%0t status mismatch expected %0d actual %0d", $time, a.status, st);
        errors++;
      end
      if (fv !== a.found_value) begin
        $display("%0t found_value mismatch expected %h actual %h", $time, a.found_value, fv);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 0;
  logic rst_ni = 0;
  cht_req_if req();
  cht_rsp_if rsp();
  answer_board board = new();
  bit calm = 0;
  bit hold_long = 0;
  logic [63:0] key_pool [16];

  coalesced_hash_table_core uut (.clk_i(clk_i), .rst_ni(rst_ni), .req_i(req), .rsp_o(rsp));

  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

  // check accepted results
  always @(posedge clk_i) begin
    if (rst_ni && rsp.valid && rsp.ready) board.check_answer(rsp.status, rsp.found_value);
  end

  // response side backpressure
  initial begin
    rsp.ready = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_long) begin
        rsp.ready <= 0;
        repeat (300) @(posedge clk_i);
        hold_long = 0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        rsp.ready <= 0;
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
      end
      rsp.ready <= 1;
    end
  end

  task automatic send(logic [1:0] op, logic [63:0] k, logic [63:0] v);
    if (!calm && $urandom_range(0, 5) == 0) begin
      req.valid <= 0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    req.valid <= 1; req.operation <= op; req.key_text <= k; req.value <= v;
    do @(posedge clk_i); while (!req.ready);
    board.note_request(op, k, v);
  endtask

  function automatic logic [63:0] pick_key();
    logic [63:0] k;
    k = key_pool[$urandom_range(0, 15)];
    // letters, yo and non-letters in the hashed bytes
    if ($urandom_range(0, 3) == 0) k[63:56] = 8'(($urandom_range(0, 1)) ? 8'hA8 : 8'hB8);
    return k;
  endfunction

  initial begin
    logic [63:0] k;
    req.valid = 0; req.operation = cht_pkg::OP_ADD; req.key_text = '0; req.value = '0;
    for (int i = 0; i < 16; i++) begin
      key_pool[i] = {$urandom, $urandom};
      // mostly cyrillic letters in upper or lower case so homes collide
      for (int b = 0; b < 3; b++)
        if ($urandom_range(0, 4) != 0) key_pool[i][63-8*b -: 8] = 8'($urandom_range(8'hC0, 8'hFF));
    end
    repeat (2) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    // directed: extremes, every op, head removal, missing key, unused code
    send(cht_pkg::OP_FIND, '0, '0);
    send(cht_pkg::OP_ADD, '0, '1);
    send(cht_pkg::OP_ADD, '1, '0);
    send(cht_pkg::OP_ADD, '0, 64'h5);
    send(cht_pkg::OP_FIND, '0, '0);
    send(cht_pkg::OP_FIND, '1, '0);
    send(cht_pkg::OP_ADD, 64'hC0C0C0_0000000001, 64'h11);
    send(cht_pkg::OP_ADD, 64'hE0E0E0_0000000002, 64'h22);
    send(cht_pkg::OP_ADD, 64'hC0C0C0_0000000003, 64'h33);
    send(cht_pkg::OP_REMOVE, 64'hC0C0C0_0000000001, '0);
    send(cht_pkg::OP_FIND, 64'hE0E0E0_0000000002, '0);
    send(cht_pkg::OP_REMOVE, 64'hE0E0E0_0000000002, '0);
    send(cht_pkg::OP_REMOVE, 64'hE0E0E0_0000000002, '0);
    send(cht_pkg::OP_NOP, '1, '1);
    send(cht_pkg::OP_REMOVE, '1, '0);
    send(cht_pkg::OP_REMOVE, '0, '0);
    send(cht_pkg::OP_REMOVE, 64'hC0C0C0_0000000003, '0);
    // fill the table past capacity
    for (int i = 0; i < 34; i++)
      send(cht_pkg::OP_ADD, {8'hA8, 8'hB8, 8'hFF, 40'(i)}, {$urandom, $urandom});
    hold_long = 1;
    for (int i = 0; i < 34; i++)
      send(i % 2 ? cht_pkg::OP_REMOVE : cht_pkg::OP_FIND, {8'hA8, 8'hB8, 8'hFF, 40'(i)}, '0);
    for (int i = 0; i < 470; i++) begin
      if (i > 400) calm = 1;
      k = ($urandom_range(0, 9) == 0) ? {$urandom, $urandom} : pick_key();
      send(($urandom_range(0, 9) == 0) ? cht_pkg::OP_NOP : 2'($urandom_range(0, 2)),
           k, {$urandom, $urandom});
    end
    req.valid <= 0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (board.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
